// ===== hw/rtl/cfa_pkg.sv =====
`default_nettype none
package cfa_pkg;

  // Unpacked float operand on a binary64 exponent scale. The value is
  // mant * 2^(expo - 1075); mant need not be normalized.
  typedef struct packed {
    logic        sgn;
    logic [10:0] expo;
    logic [52:0] mant;
    logic        inf;
    logic        nan;
  } fop_t;

  localparam logic [31:0] QNAN32     = 32'h7FC0_0000;
  localparam logic [10:0] F32_SUB_EXP = 11'd897;
  localparam logic [10:0] F32_BIAS_ADJ = 11'd896;

  function automatic fop_t unpack_d(input logic [63:0] b);
    fop_t r;
    r.sgn  = b[63];
    r.nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    r.inf  = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
    r.expo = (b[62:52] == '0) ? 11'd1 : b[62:52];
    r.mant = {(b[62:52] != '0), b[51:0]};
    return r;
  endfunction

  // Subnormal singles are normalized and zero gets exponent zero, so that
  // ordering on {expo, mant} matches ordering on magnitude.
  function automatic fop_t unpack_f(input logic [31:0] b);
    fop_t       r;
    logic [4:0] lz;
    r.sgn = b[31];
    r.nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    r.inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    lz    = '0;
    for (int i = 0; i < 23; i++) begin
      if (b[i]) lz = 5'(22 - i);
    end
    if (b[30:23] != '0) begin
      r.expo = {3'b000, b[30:23]} + F32_BIAS_ADJ;
      r.mant = {1'b1, b[22:0], 29'd0};
    end else if (b[22:0] == '0) begin
      r.expo = '0;
      r.mant = '0;
    end else begin
      r.mant = {1'b0, b[22:0], 29'd0} << (lz + 5'd1);
      r.expo = F32_SUB_EXP - {6'd0, lz} - 11'd1;
    end
    return r;
  endfunction

  function automatic fop_t negate(input fop_t a);
    fop_t r;
    r     = a;
    r.sgn = ~a.sgn;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cfa_if.sv =====
`default_nettype none
interface cfa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] term;
  logic        last_term;
  modport source (output valid, term, last_term, input ready);
  modport sink   (input valid, term, last_term, output ready);
endinterface

interface cfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total;
  modport source (output valid, total, input ready);
  modport sink   (input valid, total, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cfa_fadd.sv =====
`default_nettype none
// Exact sum of two operands, rounded once to binary32, nearest even.
module cfa_fadd (
  input  var cfa_pkg::fop_t a,
  input  var cfa_pkg::fop_t b,
  output logic [31:0]       sum_bits
);
  import cfa_pkg::*;

  fop_t               big, sml;
  logic [11:0]        dfull;
  logic [55:0]        bext, bsh, mask;
  logic               st_al;
  logic [56:0]        m, norm, nsh;
  logic [5:0]         p;
  logic signed [12:0] ex, sub_amt;
  logic [4:0]         s;
  logic               sub, st2, rnd, stk, up;
  logic [23:0]        m24;
  logic [10:0]        expb;
  logic [33:0]        pk;

  always_comb begin
    if ({a.expo, a.mant} >= {b.expo, b.mant}) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    dfull = {1'b0, big.expo} - {1'b0, sml.expo};
    bext  = {sml.mant, 3'b000};
    mask  = '0;
    if (dfull >= 12'd56) begin
      bsh   = '0;
      st_al = |sml.mant;
    end else begin
      bsh   = bext >> dfull[5:0];
      mask  = (56'd1 << dfull[5:0]) - 56'd1;
      st_al = |(bext & mask);
    end
    // Lost alignment bits are folded into the lowest bit; the three guard
    // zeros of the larger operand keep the rounding decision exact.
    if (big.sgn ^ sml.sgn) begin
      m = {1'b0, big.mant, 3'b000} - {1'b0, bsh | {55'd0, st_al}};
    end else begin
      m = {1'b0, big.mant, 3'b000} + {1'b0, bsh | {55'd0, st_al}};
    end

    p = '0;
    for (int i = 0; i < 57; i++) begin
      if (m[i]) p = 6'(i);
    end
    norm = m << (6'd56 - p);
    ex   = $signed({2'b00, big.expo}) - 13'sd1078 + $signed({7'd0, p});

    sub_amt = -13'sd126 - ex;
    sub     = (ex < -13'sd126);
    if (!sub) begin
      s = '0;
    end else if (sub_amt >= 13'sd26) begin
      s = 5'd26;
    end else begin
      s = sub_amt[4:0];
    end
    nsh = norm >> s;
    st2 = |(norm & ((57'd1 << s) - 57'd1));
    m24 = nsh[56:33];
    rnd = nsh[32];
    stk = (|nsh[31:0]) | st2;
    up  = rnd & (stk | m24[0]);

    expb = sub ? 11'd0 : (ex[10:0] + 11'd127);
    pk   = {expb, m24[22:0]} + {33'd0, up};

    if (a.nan || b.nan || (a.inf && b.inf && (a.sgn != b.sgn))) begin
      sum_bits = QNAN32;
    end else if (a.inf) begin
      sum_bits = {a.sgn, 8'hFF, 23'd0};
    end else if (b.inf) begin
      sum_bits = {b.sgn, 8'hFF, 23'd0};
    end else if (m == '0) begin
      sum_bits = {a.sgn & b.sgn, 31'd0};
    end else if (pk >= {11'd255, 23'd0}) begin
      sum_bits = {big.sgn, 8'hFF, 23'd0};
    end else begin
      sum_bits = {big.sgn, pk[30:0]};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/compensated_float_accumulator.sv =====
// A sum is registered and offered in the cycle after its last term is accepted.
// Throughput: one term per cycle unless stalled; all four rounded additions of a
// term settle in one combinational pass from the sum and compensation registers.
// Input is held off only while a finished sum waits on a stalled output.
// Reset (synchronous, active low) sets sum and compensation to positive zero.
`default_nettype none
module compensated_float_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  cfa_in_if.sink    in_chan,
  cfa_out_if.source out_chan
);
  import cfa_pkg::*;

  logic [31:0] sum_r, sum_nxt, comp_r, comp_nxt, total_r;
  logic        out_valid_r;
  logic [31:0] y_bits, t_bits, d_bits, c_bits;
  logic        accept;

  cfa_fadd u_sub_y (
    .a(unpack_d(in_chan.term)), .b(negate(unpack_f(comp_r))), .sum_bits(y_bits));
  cfa_fadd u_add_t (
    .a(unpack_f(sum_r)), .b(unpack_f(y_bits)), .sum_bits(t_bits));
  cfa_fadd u_sub_d (
    .a(unpack_f(t_bits)), .b(negate(unpack_f(sum_r))), .sum_bits(d_bits));
  cfa_fadd u_sub_c (
    .a(unpack_f(d_bits)), .b(negate(unpack_f(y_bits))), .sum_bits(c_bits));

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.total = total_r;

  always_comb begin
    sum_nxt  = sum_r;
    comp_nxt = comp_r;
    if (accept) begin
      if (in_chan.last_term) begin
        sum_nxt  = '0;
        comp_nxt = '0;
      end else begin
        sum_nxt  = t_bits;
        comp_nxt = c_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      comp_r <= comp_nxt;
      if (accept && in_chan.last_term) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last_term) begin
      total_r <= t_bits;
    end
  end

endmodule
`default_nettype wire
